// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on i_clk, off while reset is asserted
`define TRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check sampled on i_clk, also active during reset
`define TRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/trp_pkg.sv
package trp_pkg;

    // Width of the record counter (range 4 to 32)
    localparam int RECORD_COUNT_WIDTH = 16;

    // Parse phase codes
    localparam logic [1:0] PH_TAG = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_VALUE = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef logic [RECORD_COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [7:0]  record_tag;
        logic [7:0]  value_byte;
        logic        record_end;
        logic [1:0]  status;
        logic [15:0] record_number;
    } t_result;

    // Result handed from the parser to the output stage
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    // Parser state visible to the top level
    typedef struct packed {
        logic [1:0] phase;
        logic       count_zero;
    } t_core_stat;

    // Record count shown on the 16-bit result field: low bits, zero extended
    function automatic logic [15:0] count_to_number(t_count cnt);
        logic [RECORD_COUNT_WIDTH+15:0] ext;
        ext = {16'b0, cnt};
        return ext[15:0];
    endfunction

endpackage

// File: design/trp_in_if.sv
interface trp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// File: design/trp_out_if.sv
interface trp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  record_tag;
    logic [7:0]  value_byte;
    logic        record_end;
    logic [1:0]  status;
    logic [15:0] record_number;

    modport source (output valid, output record_tag, output value_byte, output record_end,
                    output status, output record_number, input ready);
    modport sink   (input valid, input record_tag, input value_byte, input record_end,
                    input status, input record_number, output ready);
endinterface

// File: design/trp_parse_core.sv
module trp_parse_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_buffer_end,
    output trp_pkg::t_push      o_push,
    output trp_pkg::t_core_stat o_stat
);
    import trp_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_tag, n_tag;
    logic [7:0] r_remain, n_remain;
    t_count     r_count, n_count;

    logic [7:0] remain_dec;
    logic       emit;
    logic [7:0] emit_value;
    logic       emit_end;
    logic [1:0] emit_status;
    logic       count_inc;

    assign remain_dec = r_remain - 8'd1;

    // Decode one byte against the current phase
    always_comb begin
        n_phase     = r_phase;
        n_tag       = r_tag;
        n_remain    = r_remain;
        emit        = 1'b0;
        emit_value  = 8'd0;
        emit_end    = 1'b0;
        emit_status = ST_VALUE;
        count_inc   = 1'b0;
        unique case (r_phase)
            PH_LEN: begin
                n_remain = i_data_byte;
                if (i_data_byte == 8'd0) begin
                    emit        = 1'b1;
                    emit_end    = 1'b1;
                    emit_status = ST_EMPTY;
                    count_inc   = 1'b1;
                    n_phase     = PH_TAG;
                end else if (i_buffer_end) begin
                    emit        = 1'b1;
                    emit_end    = 1'b1;
                    emit_status = ST_TRUNC;
                end else begin
                    n_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                n_remain   = remain_dec;
                emit       = 1'b1;
                emit_value = i_data_byte;
                if (remain_dec == 8'd0) begin
                    emit_end  = 1'b1;
                    count_inc = 1'b1;
                    n_phase   = PH_TAG;
                end else if (i_buffer_end) begin
                    emit_end    = 1'b1;
                    emit_status = ST_TRUNC;
                end
            end
            default: begin
                // tag byte; the unused phase code behaves the same
                n_tag   = i_data_byte;
                n_phase = PH_LEN;
            end
        endcase

        // saturating record count
        n_count = r_count;
        if (count_inc && (r_count != '1)) begin
            n_count = r_count + t_count'(1);
        end

        // final byte of a buffer returns to the start state
        if (i_buffer_end) begin
            n_phase  = PH_TAG;
            n_tag    = 8'd0;
            n_remain = 8'd0;
            n_count  = '0;
        end
    end

    // State registers advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_tag    <= 8'd0;
            r_remain <= 8'd0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_remain <= n_remain;
            r_count  <= n_count;
        end
    end

    // Result uses tag and count as they stood before this byte
    assign o_push.valid             = i_accept && emit;
    assign o_push.res.record_tag    = r_tag;
    assign o_push.res.value_byte    = emit_value;
    assign o_push.res.record_end    = emit_end;
    assign o_push.res.status        = emit_status;
    assign o_push.res.record_number = count_to_number(r_count);

    assign o_stat.phase      = r_phase;
    assign o_stat.count_zero = (r_count == '0);

endmodule

// File: design/trp_out_stage.sv
module trp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trp_pkg::t_push   i_push,
    input  logic             i_pop_ready,
    output logic             o_valid,
    output trp_pkg::t_result o_res,
    output logic             o_space
);
    import trp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && i_pop_ready;

    // Valid flags: output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else begin
            r_out_valid  <= i_push.valid || (r_out_valid && !pop);
            r_skid_valid <= i_push.valid && r_out_valid && !pop;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push.valid) begin
            if (!r_out_valid || pop) begin
                r_out <= i_push.res;
            end else begin
                r_skid <= i_push.res;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_space = !r_skid_valid;

endmodule

// File: design/tlv_record_parser.sv
// TLV record parser: takes one buffer byte per cycle (tag, length, value bytes, with
// buffer_end on the last byte) and gives one result per value byte, one per empty
// record, and a truncated result when the buffer ends inside a record after its tag
// byte; a consumer must drop a record whose last result is marked truncated.
// Throughput is one byte per cycle while input ready is high. The output has a register
// and one skid entry, so input ready drops only while the skid entry is held, i.e. after
// the output stalled with a result pending. No clearing pass after reset.
`include "assert_macros.svh"

module tlv_record_parser (
    input  logic i_clk,
    input  logic i_rst_n,
    trp_in_if.sink    i_in,
    trp_out_if.source o_out
);
    import trp_pkg::*;

    logic       accept;
    logic       space;
    t_push      push;
    t_core_stat core_stat;
    t_result    res;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    // Byte decode and parse state
    trp_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_in.data_byte),
        .i_buffer_end (i_in.buffer_end),
        .o_push       (push),
        .o_stat       (core_stat)
    );

    // Result register with skid entry
    trp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_res       (res),
        .o_space     (space)
    );

    assign o_out.record_tag    = res.record_tag;
    assign o_out.value_byte    = res.value_byte;
    assign o_out.record_end    = res.record_end;
    assign o_out.status        = res.status;
    assign o_out.record_number = res.record_number;

    // Checks
    `TRP_ASSERT(a_skid_needs_out, !i_in.ready |-> o_out.valid, "skid full with empty output")
    `TRP_ASSERT(a_stall_fills_skid, push.valid && o_out.valid && !o_out.ready |=> !i_in.ready, "stalled result not kept in skid")
    `TRP_ASSERT(a_end_restarts, accept && i_in.buffer_end |=> core_stat.phase == PH_TAG && core_stat.count_zero, "buffer end did not restart parser")
    `TRP_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out.valid && i_in.ready, "reset left a result pending")

endmodule
